FILE: hdl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define SCFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("scfr assertion failed");

// Clocked property checked on every edge, reset included.
`define SCFR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("scfr assertion failed");

`endif

FILE: hdl/scfr_pkg.sv
// Types and constants for the sum-checked frame receiver.
`default_nettype none

package scfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LIMIT_W  = 9;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] MIN_LENGTH = 8'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 8'd1;

    localparam logic [BYTE_W-1:0]  START_BYTE_RST   = 8'd170;
    localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST = 9'd256;

    // Result word kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // End status codes
    localparam logic [1:0] STAT_GOOD      = 2'd0;
    localparam logic [1:0] STAT_BAD_SOF   = 2'd1;
    localparam logic [1:0] STAT_BAD_LEN   = 2'd2;
    localparam logic [1:0] STAT_BAD_CHECK = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              kind;
        logic [1:0]        status;
        logic              last_payload;
        logic [BYTE_W-1:0] frame_length;
    } t_result;

    typedef enum logic [4:0] {
        ST_HUNT  = 5'b00001,
        ST_SOF2  = 5'b00010,
        ST_LEN   = 5'b00100,
        ST_DATA  = 5'b01000,
        ST_CHECK = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/scfr_front.sv
// Frame parser: holds configuration, walks the frame phases, emits result words.
`default_nettype none
`include "assert_macros.svh"

module scfr_front
    import scfr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    input  wire logic                 i_rx_valid,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    input  wire logic                 i_full,
    output logic                      o_rx_stall,
    output logic                      o_push,
    output t_result                   o_result
);

    logic [BYTE_W-1:0]  r_start_byte;
    logic [LIMIT_W-1:0] r_length_limit;
    t_state             r_state, n_state;
    logic [BYTE_W-1:0]  r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]  r_sum, n_sum;
    logic [BYTE_W-1:0]  r_length, n_length;

    logic               accept;
    logic [BYTE_W-1:0]  sum_add;
    logic [BYTE_W-1:0]  left_dec;
    logic               len_ok;

    assign o_rx_stall = i_full;
    assign accept     = i_rx_valid && !i_full;
    assign sum_add    = r_sum + i_rx_byte;
    assign left_dec   = r_bytes_left - 8'd1;
    assign len_ok     = (i_rx_byte >= MIN_LENGTH) && ({1'b0, i_rx_byte} < r_length_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= START_BYTE_RST;
            r_length_limit <= LENGTH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_START_BYTE) begin
                r_start_byte <= i_cfg_data[BYTE_W-1:0];
            end else if (i_cfg_index == REG_LENGTH_LIMIT) begin
                r_length_limit <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_length     = r_length;
        o_push       = 1'b0;
        o_result     = '0;
        if (accept) begin
            case (r_state)
                ST_SOF2: begin
                    if (i_rx_byte == r_start_byte) begin
                        n_state = ST_LEN;
                    end else begin
                        n_state          = ST_HUNT;
                        o_push           = 1'b1;
                        o_result.kind    = KIND_END;
                        o_result.status  = STAT_BAD_SOF;
                    end
                end
                ST_LEN: begin
                    if (len_ok) begin
                        n_length     = i_rx_byte;
                        n_bytes_left = i_rx_byte;
                        n_sum        = '0;
                        n_state      = ST_DATA;
                    end else begin
                        n_state               = ST_HUNT;
                        o_push                = 1'b1;
                        o_result.kind         = KIND_END;
                        o_result.status       = STAT_BAD_LEN;
                        o_result.frame_length = i_rx_byte;
                    end
                end
                ST_DATA: begin
                    n_sum        = sum_add;
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        n_state = ST_CHECK;
                    end
                    o_push                = 1'b1;
                    o_result.byte_value   = i_rx_byte;
                    o_result.kind         = KIND_PAYLOAD;
                    o_result.status       = STAT_GOOD;
                    o_result.last_payload = (left_dec == '0);
                    o_result.frame_length = r_length;
                end
                ST_CHECK: begin
                    n_state               = ST_HUNT;
                    o_push                = 1'b1;
                    o_result.kind         = KIND_END;
                    o_result.status       = (sum_add == '0) ? STAT_GOOD : STAT_BAD_CHECK;
                    o_result.frame_length = r_length;
                end
                default: begin
                    n_state = (i_rx_byte == r_start_byte) ? ST_SOF2 : ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_HUNT;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_length     <= '0;
        end else begin
            r_state      <= n_state;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_length     <= n_length;
        end
    end

    // last payload byte always hands over to the checksum phase
    `SCFR_ASSERT(a_last_to_check, i_clk, i_rst_n,
        (accept && r_state == ST_DATA && r_bytes_left == 8'd1) |=> (r_state == ST_CHECK))
    // a frame never runs with a length below the minimum
    `SCFR_ASSERT(a_len_min, i_clk, i_rst_n,
        (r_state == ST_DATA) |-> (r_length >= MIN_LENGTH && r_bytes_left != 8'd0))

endmodule

`default_nettype wire

FILE: hdl/scfr_queue.sv
// Short result-word queue between the parser and the output stage.
`default_nettype none
`include "assert_macros.svh"

module scfr_queue
    import scfr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_empty,
    output t_result      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // a push is never offered while the queue is full
    `SCFR_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    // read and write pointers coincide whenever the queue is empty or full
    `SCFR_ASSERT(a_ptr_count, i_clk, i_rst_n,
        (r_count == '0 || r_count == CNT_FULL) |-> (r_wr_ptr == r_rd_ptr))

endmodule

`default_nettype wire

FILE: hdl/scfr_back.sv
// Output stage: pulls result words from the queue into the port register.
`default_nettype none
`include "assert_macros.svh"

module scfr_back
    import scfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_empty,
    input  wire t_result i_data,
    input  wire logic    i_res_stall,
    output logic         o_pop,
    output logic         o_res_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_data;

    assign o_pop       = !i_empty && (!r_valid || !i_res_stall);
    assign o_res_valid = r_valid;
    assign o_result    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_res_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    // a waiting queue word fills an empty output register on the next edge
    `SCFR_ASSERT(a_fill, i_clk, i_rst_n, (!r_valid && !i_empty) |=> r_valid)

endmodule

`default_nettype wire

FILE: hdl/sum_checked_frame_receiver_unit.sv
// Top level of the sum-checked frame receiver.
`default_nettype none

// Receives a byte stream and pulls out frames of the form: start byte, start
// byte, length byte L (2 <= L < length_limit), L payload bytes, checksum byte.
// Each payload byte comes out as its own result word (kind 0, last_payload
// set on the final one), and every frame attempt ends with one status word
// (kind 1): good, bad second start, bad length, or bad checksum, where the
// payload bytes plus checksum must sum to zero mod 256. After a status word
// the parser hunts for a start byte again beginning with the following byte.
// The parser takes one byte per clock while the queue is not full, doing a
// compare and an 8-bit add per byte. A result word is written into the queue
// on the edge that takes its byte and then moves into the output register
// that drives o_res_valid once that register is empty or its word is taken.
// The parser and the output register are decoupled by a QUEUE_DEPTH-word
// queue, so a downstream stall only backs up into o_rx_stall once the queue
// is full. Config writes (index 0 start_byte, index 1 length_limit, other
// indexes ignored) are always ready and must only happen while idle.
module sum_checked_frame_receiver_unit
    import scfr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write port
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0]   i_cfg_data,
    // received byte in
    input  wire logic                 i_rx_valid,
    output logic                      o_rx_stall,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    // result word out
    output logic                      o_res_valid,
    input  wire logic                 i_res_stall,
    output logic [BYTE_W-1:0]         o_byte_value,
    output logic                      o_kind,
    output logic [1:0]                o_status,
    output logic                      o_last_payload,
    output logic [BYTE_W-1:0]         o_frame_length
);

    logic    push, pop, q_full, q_empty;
    t_result front_word, q_word, out_word;

    // registers are plain flops; a write is taken every cycle
    assign o_cfg_ready = 1'b1;

    scfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_valid  (i_rx_valid),
        .i_rx_byte   (i_rx_byte),
        .i_full      (q_full),
        .o_rx_stall  (o_rx_stall),
        .o_push      (push),
        .o_result    (front_word)
    );

    scfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_word),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_word)
    );

    scfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_data      (q_word),
        .i_res_stall (i_res_stall),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_result    (out_word)
    );

    // unpack the result word onto the field ports
    assign o_byte_value   = out_word.byte_value;
    assign o_kind         = out_word.kind;
    assign o_status       = out_word.status;
    assign o_last_payload = out_word.last_payload;
    assign o_frame_length = out_word.frame_length;

endmodule

`default_nettype wire

FILE: dv/tb_sum_checked_frame_receiver_unit.sv
// Self-checking testbench for the sum-checked frame receiver, random traffic on both sides.
`timescale 1ns / 100ps

module tb_sum_checked_frame_receiver_unit;
    import scfr_pkg::*;

    // Cycles to let pass after the last expected word before a register write,
    // covering the output register path plus the output queue.
    localparam int unsigned SETTLE_CYCLES = 10;
    // Hard stop, several times the slowest correct run.
    localparam int unsigned RUN_LIMIT_NS  = 2_000_000;
    // Indexes the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;
    localparam logic [BYTE_W-1:0]    MAX_LENGTH    = 8'd255;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;
    logic                 rx_valid = 1'b0;
    logic                 rx_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [BYTE_W-1:0]    res_byte_value;
    logic                 res_kind;
    logic [1:0]           res_status;
    logic                 res_last_payload;
    logic [BYTE_W-1:0]    res_frame_length;

    sum_checked_frame_receiver_unit u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_rx_valid     (rx_valid),
        .o_rx_stall     (rx_stall),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .o_byte_value   (res_byte_value),
        .o_kind         (res_kind),
        .o_status       (res_status),
        .o_last_payload (res_last_payload),
        .o_frame_length (res_frame_length)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the receiver: register copies and parser state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  cfg_start = START_BYTE_RST;
    logic [LIMIT_W-1:0] cfg_limit = LENGTH_LIMIT_RST;
    t_state             prs_state = ST_HUNT;
    logic [BYTE_W-1:0]  prs_left  = '0;
    logic [BYTE_W-1:0]  prs_sum   = '0;
    logic [BYTE_W-1:0]  prs_len   = '0;

    logic [BYTE_W-1:0] rx_pending [$];   // bytes waiting for the driver
    t_result           want_words [$];   // predicted result words, oldest first

    int unsigned errors    = 0;
    int unsigned bytes_in  = 0;
    int unsigned words_out = 0;
    int unsigned end_seen [4] = '{0, 0, 0, 0};
    int unsigned queued    = 0;          // bytes queued in the current phase

    // Steps the shadow parser by one accepted byte, queueing the word it causes.
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        t_result           w;
        logic [BYTE_W-1:0] total;
        w = '0;
        case (prs_state)
            ST_SOF2: begin
                if (b == cfg_start) begin
                    prs_state = ST_LEN;
                end else begin
                    prs_state = ST_HUNT;
                    w.kind    = KIND_END;
                    w.status  = STAT_BAD_SOF;
                    want_words.push_back(w);
                end
            end
            ST_LEN: begin
                if (b >= MIN_LENGTH && {1'b0, b} < cfg_limit) begin
                    prs_len   = b;
                    prs_left  = b;
                    prs_sum   = '0;
                    prs_state = ST_DATA;
                end else begin
                    // rejected length travels in frame_length
                    prs_state      = ST_HUNT;
                    w.kind         = KIND_END;
                    w.status       = STAT_BAD_LEN;
                    w.frame_length = b;
                    want_words.push_back(w);
                end
            end
            ST_DATA: begin
                prs_sum        = prs_sum + b;
                prs_left       = prs_left - 1'b1;
                w.byte_value   = b;
                w.kind         = KIND_PAYLOAD;
                w.status       = STAT_GOOD;
                w.last_payload = (prs_left == '0);
                w.frame_length = prs_len;
                if (prs_left == '0) begin
                    prs_state = ST_CHECK;
                end
                want_words.push_back(w);
            end
            ST_CHECK: begin
                total          = prs_sum + b;
                prs_state      = ST_HUNT;
                w.kind         = KIND_END;
                w.status       = (total == '0) ? STAT_GOOD : STAT_BAD_CHECK;
                w.frame_length = prs_len;
                want_words.push_back(w);
            end
            default: begin
                // hunting: the byte that ended a failed frame is never re-examined,
                // since the failure branches above already consumed it
                prs_state = (b == cfg_start) ? ST_SOF2 : ST_HUNT;
            end
        endcase
    endtask

    // Idle stretch: mostly short, now and then long.
    function automatic int unsigned idle_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: pops rx_pending, inserts random gaps, keeps a stalled
    // word steady, and feeds the shadow parser on every accepted word.
    // ------------------------------------------------------------------
    int unsigned rx_gap   = 0;
    bit          rx_quiet = 1'b0;   // stretch with no gaps

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else begin
            if (rx_valid && !rx_stall) begin
                parse_rx_byte(rx_byte);
                bytes_in++;
            end
            if (!rx_valid || !rx_stall) begin
                if (rx_gap != 0) begin
                    rx_gap--;
                    rx_valid <= 1'b0;
                end else if (rx_pending.size() != 0) begin
                    rx_byte  <= rx_pending.pop_front();
                    rx_valid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) begin
                        rx_quiet = !rx_quiet;
                    end
                    rx_gap = (!rx_quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0;
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: checks each taken word against the oldest prediction
    // and drives random stall on the result side.
    // ------------------------------------------------------------------
    int unsigned res_hold  = 0;
    bit          res_quiet = 1'b0;
    t_result     want_w;

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                words_out++;
                if (want_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual kind %0d status %0d byte %0d",
                             $time, res_kind, res_status, res_byte_value);
                    errors++;
                end else begin
                    want_w = want_words.pop_front();
                    check_field("byte_value", want_w.byte_value, res_byte_value);
                    check_field("kind", want_w.kind, res_kind);
                    check_field("status", want_w.status, res_status);
                    check_field("last_payload", want_w.last_payload, res_last_payload);
                    check_field("frame_length", want_w.frame_length, res_frame_length);
                    if (want_w.kind == KIND_END) begin
                        end_seen[want_w.status]++;
                    end
                end
            end
            if ($urandom_range(0, 99) == 0) begin
                res_quiet = !res_quiet;
            end
            if (res_hold == 0 && !res_quiet && $urandom_range(0, 5) == 0) begin
                res_hold = idle_len();
            end
            if (res_hold != 0) begin
                res_stall <= 1'b1;
                res_hold--;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_rx(input logic [BYTE_W-1:0] b);
        rx_pending.push_back(b);
        queued++;
    endtask

    // Register write; only called with the receiver idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_START_BYTE:   cfg_start = val[BYTE_W-1:0];
            REG_LENGTH_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    // Waits until every queued byte is taken and every predicted word seen,
    // then lets the pipeline settle for bytes that cause no word.
    task automatic wait_idle();
        while (rx_pending.size() != 0 || rx_valid || want_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Complete frame with random payload; corrupt spoils the checksum.
    task automatic queue_frame(input logic [BYTE_W-1:0] len, input bit corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        push_rx(cfg_start);
        push_rx(cfg_start);
        push_rx(len);
        repeat (len) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_rx(b);
        end
        b = -sum;
        if (corrupt) begin
            b = b + 8'($urandom_range(1, 255));
        end
        push_rx(b);
    endtask

    // Mostly short lengths that the current limit accepts.
    function automatic logic [BYTE_W-1:0] pick_len();
        int unsigned upper;
        if (cfg_limit > 256) begin
            upper = MAX_LENGTH;
        end else if (cfg_limit <= MIN_LENGTH) begin
            upper = MIN_LENGTH;   // every length gets rejected anyway
        end else begin
            upper = cfg_limit - 1;
        end
        if ($urandom_range(0, 99) < 85) begin
            return 8'($urandom_range(MIN_LENGTH, (upper < 6) ? upper : 6));
        end
        return 8'($urandom_range(MIN_LENGTH, (upper < 30) ? upper : 30));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_bad_len();
        if (cfg_limit <= MIN_LENGTH) begin
            return 8'($urandom_range(0, 255));
        end
        if (cfg_limit > 255 || $urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(0, MIN_LENGTH - 1));
        end
        return 8'($urandom_range(cfg_limit, 255));
    endfunction

    // One random sequence: mostly well-formed frames, the rest broken or noise.
    task automatic queue_random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 6)) push_rx(8'($urandom_range(0, 255)));
        end else if (pick < 20) begin
            push_rx(cfg_start);
            push_rx(cfg_start ^ 8'($urandom_range(1, 255)));
        end else if (pick < 28) begin
            push_rx(cfg_start);
            push_rx(cfg_start);
            push_rx(pick_bad_len());
        end else begin
            queue_frame(pick_len(), pick < 38);
        end
    endtask

    // One register setting followed by random traffic.
    task automatic run_phase(input logic [BYTE_W-1:0] start, input logic [LIMIT_W-1:0] limit,
                             input bit with_longest, input int unsigned budget);
        write_reg(REG_START_BYTE, {1'b0, start});
        write_reg(REG_LENGTH_LIMIT, limit);
        queued = 0;
        if (with_longest) begin
            queue_frame(MAX_LENGTH, 1'b0);
        end
        while (queued < budget) begin
            queue_random_sequence();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [BYTE_W-1:0] directed [$];

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings: good frame with payload extremes, bad second
        // start, length under the minimum, bad checksum, then hunting noise
        // running into a bad second start of zero.
        directed = '{START_BYTE_RST, START_BYTE_RST, 8'h02, 8'h00, 8'hFF, 8'h01,
                     START_BYTE_RST, 8'h55,
                     START_BYTE_RST, START_BYTE_RST, 8'h01,
                     START_BYTE_RST, START_BYTE_RST, 8'h03, 8'h10, 8'h20, 8'h30, 8'h00,
                     8'h00, 8'hFF, START_BYTE_RST, 8'h00};
        foreach (directed[i]) begin
            push_rx(directed[i]);
        end
        wait_idle();

        // Settings sweep: start byte extremes, limit just above the minimum,
        // above 256 with a longest frame, at and under the minimum where every
        // length fails (start byte 1 is itself a bad length), a middle limit,
        // and back to the reset values with ignored indexes written alongside.
        run_phase(8'h00, 9'd3,   1'b0, 80);
        run_phase(8'hFF, 9'd511, 1'b1, 110);
        run_phase(8'h01, 9'd2,   1'b0, 60);
        run_phase(8'h5A, 9'd0,   1'b0, 45);
        run_phase(8'hA5, 9'd100, 1'b0, 80);
        write_reg(REG_UNUSED_LO, 9'd0);
        write_reg(REG_UNUSED_HI, 9'h1FF);
        run_phase(START_BYTE_RST, LENGTH_LIMIT_RST, 1'b0, 80);

        $display("run covered %0d bytes in and %0d result words out over 7 register settings",
                 bytes_in, words_out);
        $display("frame ends: %0d good, %0d bad start, %0d bad length, %0d bad checksum",
                 end_seen[STAT_GOOD], end_seen[STAT_BAD_SOF], end_seen[STAT_BAD_LEN],
                 end_seen[STAT_BAD_CHECK]);
        if (errors == 0) begin
            $display("** sum_checked_frame_receiver_unit: PASSED **");
        end else begin
            $display("** sum_checked_frame_receiver_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, %0d words still expected", $time, want_words.size());
        $display("** sum_checked_frame_receiver_unit: FAILED **");
        $finish;
    end

endmodule
